/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(name, clk, rst_n, pre, post)
`define ASSERT_NXT(name, clk, rst_n, pre, post)

`endif

`endif

/* sv/tapqm_pkg.sv */
// ----------------------------------------------------------------------------
// tapqm_pkg
// Shared widths, constants and types of the three-axis PID quad mixer.
// ----------------------------------------------------------------------------
package tapqm_pkg;

    localparam int ANGLE_WIDTH     = 16;
    localparam int GAIN_WIDTH      = 16;
    localparam int GAINS_WIDTH     = 48;
    localparam int LIMIT_WIDTH     = 10;
    localparam int THRESH_WIDTH    = 11;
    localparam int INTERVAL_WIDTH  = 16;
    localparam int TIME_WIDTH      = 32;
    localparam int MOTOR_WIDTH     = 11;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int AXES            = 3;
    localparam int MOTORS          = 4;

    localparam int TERM_FRAC = 14;

    localparam int ERR_W   = ANGLE_WIDTH + 1;
    localparam int DERR_W  = ERR_W + 1;
    localparam int PROD_W  = GAIN_WIDTH + 1 + ERR_W;
    localparam int DPROD_W = GAIN_WIDTH + 1 + DERR_W;
    localparam int LIM_W   = LIMIT_WIDTH + TERM_FRAC;
    localparam int INT_W   = LIM_W + 1;
    localparam int ACC_W   = ((PROD_W > INT_W) ? PROD_W : INT_W) + 1;
    localparam int SUM_W   = ((DPROD_W > INT_W) ? DPROD_W : INT_W) + 2;
    localparam int THR_Q_W = MOTOR_WIDTH + TERM_FRAC + 1;
    localparam int MIX_W   = ((THR_Q_W > INT_W) ? THR_Q_W : INT_W) + 2;

    localparam int MOTOR_IDLE_US = 1000;
    localparam int MOTOR_MIN_US  = 1100;
    localparam int MOTOR_MAX_US  = 2000;
    localparam int Q_MIN         = MOTOR_MIN_US * (1 << TERM_FRAC);
    localparam int Q_MAX         = MOTOR_MAX_US * (1 << TERM_FRAC);

    localparam logic [MOTOR_WIDTH-1:0] MOTOR_IDLE = MOTOR_WIDTH'(MOTOR_IDLE_US);

    localparam logic [LIMIT_WIDTH-1:0]    AXIS_LIMIT_RESET = LIMIT_WIDTH'(400);
    localparam logic [LIMIT_WIDTH-1:0]    YAW_LIMIT_RESET  = LIMIT_WIDTH'(400);
    localparam logic [THRESH_WIDTH-1:0]   IDLE_THRESH_RESET = THRESH_WIDTH'(1050);
    localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET   = INTERVAL_WIDTH'(4);

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROLL_GAINS      = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PITCH_GAINS     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_YAW_GAINS       = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_LIMIT      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_YAW_LIMIT       = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_IDLE_THRESHOLD  = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPDATE_INTERVAL = 3'd6;

    // input word layout
    localparam int OFF_THROTTLE = 0;
    localparam int OFF_LAUNCH   = OFF_THROTTLE + MOTOR_WIDTH;
    localparam int OFF_NOW      = OFF_LAUNCH + 1;
    localparam int OFF_MEAS     = OFF_NOW + TIME_WIDTH;
    localparam int OFF_TGT      = OFF_MEAS + AXES * ANGLE_WIDTH;
    localparam int IN_BITS      = OFF_TGT + AXES * ANGLE_WIDTH;
    localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS = MOTORS * MOTOR_WIDTH + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic clear;
        logic step;
        logic launch;
    } axis_ctl_t;

endpackage

/* sv/tapqm_pid_axis.sv */
// ----------------------------------------------------------------------------
// tapqm_pid_axis
// One PID axis: clamped integral, derivative on error and clamped sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tapqm_pid_axis
    import tapqm_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  axis_ctl_t                      ctl,
    input  logic [GAINS_WIDTH-1:0]         gains,
    input  logic [LIMIT_WIDTH-1:0]         limit,
    input  logic signed [ANGLE_WIDTH-1:0]  measured,
    input  logic signed [ANGLE_WIDTH-1:0]  target,
    output logic signed [INT_W-1:0]        sum
);

    logic signed [INT_W-1:0]   integral_reg;
    logic signed [INT_W-1:0]   integral_next;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [ERR_W-1:0]   prev_err_next;

    logic [3*GAIN_WIDTH+GAINS_WIDTH-1:0] gains_ext;
    logic [GAIN_WIDTH-1:0]     kp;
    logic [GAIN_WIDTH-1:0]     ki;
    logic [GAIN_WIDTH-1:0]     kd;
    logic signed [DERR_W-1:0]  derr;
    logic signed [PROD_W-1:0]  p_prod;
    logic signed [PROD_W-1:0]  i_prod;
    logic signed [DPROD_W-1:0] d_prod;
    logic signed [INT_W-1:0]   lim;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_lim;
    logic signed [SUM_W-1:0]   total;
    logic signed [SUM_W-1:0]   total_lim;

    always_comb
    begin
        gains_ext     = {{(3*GAIN_WIDTH){1'b0}}, gains};
        kp            = gains_ext[0 +: GAIN_WIDTH];
        ki            = gains_ext[GAIN_WIDTH +: GAIN_WIDTH];
        kd            = gains_ext[2*GAIN_WIDTH +: GAIN_WIDTH];
        lim           = $signed({1'b0, limit, {TERM_FRAC{1'b0}}});

        prev_err_next = ERR_W'(target) - ERR_W'(measured);
        derr          = DERR_W'(prev_err_next) - DERR_W'(prev_err_reg);
        p_prod        = $signed({1'b0, kp}) * prev_err_next;
        i_prod        = $signed({1'b0, ki}) * prev_err_next;
        d_prod        = $signed({1'b0, kd}) * derr;

        acc           = ACC_W'(integral_reg) + ACC_W'(i_prod);
        acc_lim       = ACC_W'(lim);
        if (ctl.launch)
        begin
            integral_next = '0;
        end
        else if (acc > acc_lim)
        begin
            integral_next = lim;
        end
        else if (acc < -acc_lim)
        begin
            integral_next = -lim;
        end
        else
        begin
            integral_next = INT_W'(acc);
        end

        total     = SUM_W'(p_prod) + SUM_W'(integral_next) + SUM_W'(d_prod);
        total_lim = SUM_W'(lim);
        if (total > total_lim)
        begin
            sum = lim;
        end
        else if (total < -total_lim)
        begin
            sum = -lim;
        end
        else
        begin
            sum = INT_W'(total);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else if (ctl.clear)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else if (ctl.step)
        begin
            integral_reg <= integral_next;
            prev_err_reg <= prev_err_next;
        end
    end

    `ASSERT_NXT(a_clear_zeroes, clk, rst_n, ctl.clear, integral_reg == '0 && prev_err_reg == '0)
    `ASSERT_NXT(a_launch_holds_zero, clk, rst_n, ctl.step && ctl.launch, integral_reg == '0)
    `ASSERT_NXT(a_step_keeps_err, clk, rst_n, ctl.step && !ctl.clear, prev_err_reg == $past(prev_err_next))

endmodule

/* sv/three_axis_pid_quad_mixer_top.sv */
// ----------------------------------------------------------------------------
// three_axis_pid_quad_mixer_top
// Roll, pitch and yaw PID with a quad-X mixer into four motor pulse widths.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per word (throttle, launch flag, time in ms,
//   measured and target angles). m_axis returns one word per sample with the
//   four motor widths in microseconds and the updated flag.
//   The cfg port writes a register at any edge with cfg_we high; write only
//   while no sample is in flight.
// Timing:
//   A sample is registered on accept and runs through the PID and mixer logic
//   from the input register; its result is registered in the output register
//   when the sample advances, which raises m_axis_tvalid.
//   Throughput is one word per cycle while m_axis is not stalled; the integral
//   and error registers update at the same edge as the result register.
// Reset:
//   Integrals, stored errors and the last update time go to zero, motors to
//   1000 us, registers to their defaults, both channels empty.
// Backpressure:
//   With m_axis stalled the result holds, one more sample is taken into the
//   input register, then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_axis_pid_quad_mixer_top
    import tapqm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [GAINS_WIDTH-1:0]     cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // throttle, launch_mode, now_ms, roll_measured, pitch_measured,
    // yaw_measured, roll_target, pitch_target, yaw_target, zero pad
    input  logic [IN_W-1:0]            s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // motor_left_front, motor_right_front, motor_left_back,
    // motor_right_back, updated, zero pad
    output logic [OUT_W-1:0]           m_axis_tdata
);

    localparam logic signed [MIX_W-1:0] QL = MIX_W'(Q_MIN);
    localparam logic signed [MIX_W-1:0] QH = MIX_W'(Q_MAX);

    logic [GAINS_WIDTH-1:0]    gains_reg [AXES];
    logic [LIMIT_WIDTH-1:0]    axis_limit_reg;
    logic [LIMIT_WIDTH-1:0]    yaw_limit_reg;
    logic [THRESH_WIDTH-1:0]   idle_thresh_reg;
    logic [INTERVAL_WIDTH-1:0] interval_reg;

    logic                      in_valid_reg;
    logic [IN_BITS-1:0]        in_data_reg;
    logic                      out_valid_reg;
    logic [MOTOR_WIDTH-1:0]    motor_reg [MOTORS];
    logic [MOTOR_WIDTH-1:0]    motor_next [MOTORS];
    logic                      updated_reg;
    logic                      updated_next;
    logic [TIME_WIDTH-1:0]     last_update_reg;

    logic                      advance;
    logic [MOTOR_WIDTH-1:0]    throttle;
    logic [TIME_WIDTH-1:0]     now_ms;
    logic [TIME_WIDTH-1:0]     elapsed;
    logic                      idle;
    logic                      due;
    axis_ctl_t                 ctl;
    logic signed [INT_W-1:0]   sums [AXES];
    logic signed [MIX_W-1:0]   thr_q;
    logic signed [MIX_W-1:0]   mix [MOTORS];

    function automatic logic [MOTOR_WIDTH-1:0] motor_out(input logic signed [MIX_W-1:0] q);
        logic signed [MIX_W-1:0] qc;
        begin
            if (q < QL)
            begin
                qc = QL;
            end
            else if (q > QH)
            begin
                qc = QH;
            end
            else
            begin
                qc = q;
            end
            return qc[TERM_FRAC +: MOTOR_WIDTH];
        end
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                gains_reg[a] <= '0;
            end
            axis_limit_reg  <= AXIS_LIMIT_RESET;
            yaw_limit_reg   <= YAW_LIMIT_RESET;
            idle_thresh_reg <= IDLE_THRESH_RESET;
            interval_reg    <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROLL_GAINS:      gains_reg[0]    <= cfg_data;
                REG_PITCH_GAINS:     gains_reg[1]    <= cfg_data;
                REG_YAW_GAINS:       gains_reg[2]    <= cfg_data;
                REG_AXIS_LIMIT:      axis_limit_reg  <= cfg_data[LIMIT_WIDTH-1:0];
                REG_YAW_LIMIT:       yaw_limit_reg   <= cfg_data[LIMIT_WIDTH-1:0];
                REG_IDLE_THRESHOLD:  idle_thresh_reg <= cfg_data[THRESH_WIDTH-1:0];
                REG_UPDATE_INTERVAL: interval_reg    <= cfg_data[INTERVAL_WIDTH-1:0];
                default:             ;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    always_comb
    begin
        throttle   = in_data_reg[OFF_THROTTLE +: MOTOR_WIDTH];
        now_ms     = in_data_reg[OFF_NOW +: TIME_WIDTH];
        elapsed    = now_ms - last_update_reg;
        idle       = {1'b0, throttle} <= {1'b0, idle_thresh_reg};
        due        = elapsed >= TIME_WIDTH'(interval_reg);
        ctl.clear  = advance && idle;
        ctl.step   = advance && !idle && due;
        ctl.launch = in_data_reg[OFF_LAUNCH];
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        tapqm_pid_axis u_axis
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .gains    (gains_reg[a]),
            .limit    ((a == AXES - 1) ? yaw_limit_reg : axis_limit_reg),
            .measured ($signed(in_data_reg[OFF_MEAS + a*ANGLE_WIDTH +: ANGLE_WIDTH])),
            .target   ($signed(in_data_reg[OFF_TGT + a*ANGLE_WIDTH +: ANGLE_WIDTH])),
            .sum      (sums[a])
        );
    end

    always_comb
    begin
        thr_q  = $signed(MIX_W'({throttle, {TERM_FRAC{1'b0}}}));
        mix[0] = thr_q + MIX_W'(sums[0]) - MIX_W'(sums[1]) - MIX_W'(sums[2]);
        mix[1] = thr_q - MIX_W'(sums[0]) - MIX_W'(sums[1]) + MIX_W'(sums[2]);
        mix[2] = thr_q + MIX_W'(sums[0]) + MIX_W'(sums[1]) + MIX_W'(sums[2]);
        mix[3] = thr_q - MIX_W'(sums[0]) + MIX_W'(sums[1]) - MIX_W'(sums[2]);
        priority if (idle)
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                motor_next[m] = MOTOR_IDLE;
            end
            updated_next = 1'b1;
        end
        else if (due)
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                motor_next[m] = motor_out(mix[m]);
            end
            updated_next = 1'b1;
        end
        else
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                motor_next[m] = motor_reg[m];
            end
            updated_next = 1'b0;
        end
    end

    // result register doubles as held motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            updated_reg     <= 1'b0;
            last_update_reg <= '0;
            for (int m = 0; m < MOTORS; m++)
            begin
                motor_reg[m] <= MOTOR_IDLE;
            end
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                updated_reg   <= updated_next;
                for (int m = 0; m < MOTORS; m++)
                begin
                    motor_reg[m] <= motor_next[m];
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ctl.step)
            begin
                last_update_reg <= now_ms;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({updated_reg, motor_reg[3], motor_reg[2],
                                   motor_reg[1], motor_reg[0]});

    `ASSERT_NXT(a_idle_motors, clk, rst_n, advance && idle,
                updated_reg && motor_reg[0] == MOTOR_IDLE && motor_reg[3] == MOTOR_IDLE)
    `ASSERT_NXT(a_hold_motors, clk, rst_n, advance && !idle && !due,
                !updated_reg && $stable(motor_reg[0]) && $stable(motor_reg[2]))
    `ASSERT_IMP(a_no_double_ctl, clk, rst_n, ctl.clear || ctl.step, advance)

endmodule
